[rtl/trig_cap_pkg.sv]
// ----------------------------------------------------------------------------
// trig_cap_pkg
// Shared constants and types of the triggered trace recorder.
// ----------------------------------------------------------------------------
package trig_cap_pkg;

  localparam int unsigned DefaultCaptureDepth = 256;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned IndexWidth  = 8;
  localparam int unsigned FillWidth   = 9;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 16;

  // input tdata: sample_a, sample_b, trigger_sample, clear, start, read_index
  localparam int unsigned InDataWidth  = 64;
  // output tdata: live_a, live_b, armed, running, fill_count, read_a, read_b
  localparam int unsigned OutDataWidth = 80;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TRIG_MODE   = 2'd0,
    CFG_TRIG_THRESH = 2'd1,
    CFG_DECIM       = 2'd2
  } cfg_idx_e;

  // trigger comparison codes; other codes act as trigger off
  typedef enum logic [2:0] {
    TRIG_OFF = 3'd0,
    TRIG_GT  = 3'd1,
    TRIG_LT  = 3'd2,
    TRIG_EQ  = 3'd3,
    TRIG_NE  = 3'd4
  } trig_mode_e;

  // item kind carried in tuser
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } op_e;

endpackage

[rtl/triggered_trace_capture.sv]
// ----------------------------------------------------------------------------
// triggered_trace_capture
// Two-channel triggered trace recorder with a single-port capture memory.
// ----------------------------------------------------------------------------
// A sample tick is accepted back to back while the output is not stalled; a
// read item blocks the next item because the capture memory has a registered
// read port. Each item gives one result, held in an output register, so a new
// item is taken while the previous result is being transferred. A clear
// request empties the store in the same cycle: a high-water mark records how
// much of the memory has been written since the last clear, and entries at or
// above it read as zero, so no clearing pass runs after reset or clear.
// ----------------------------------------------------------------------------
module triggered_trace_capture #(
  parameter int unsigned CaptureDepth = trig_cap_pkg::DefaultCaptureDepth
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write port
  input  logic                                    cfg_we_i,
  input  logic [trig_cap_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [trig_cap_pkg::CfgWidth-1:0]       cfg_wdata_i,
  // input stream
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [15:0] sample_a, [31:16] sample_b, [47:32] trigger_sample,
  // [48] clear_request, [49] start_request, [57:50] read_index, rest zero
  input  logic [trig_cap_pkg::InDataWidth-1:0]    s_axis_tdata,
  // [0] op
  input  logic                                    s_axis_tuser,
  // output stream
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // [15:0] live_a, [31:16] live_b, [32] armed, [33] running,
  // [42:34] fill_count, [58:43] read_a, [74:59] read_b, rest zero
  output logic [trig_cap_pkg::OutDataWidth-1:0]   m_axis_tdata
);

  localparam int unsigned AddrWidth = (CaptureDepth > 1) ? $clog2(CaptureDepth) : 1;
  localparam int unsigned PosWidth  = $clog2(CaptureDepth + 1);
  localparam int unsigned SW        = trig_cap_pkg::SampleWidth;

  // configuration registers
  logic [2:0]           trig_mode_q;
  logic signed [SW-1:0] trig_thresh_q;
  logic [SW-1:0]        decim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_mode_q   <= 3'd0;
      trig_thresh_q <= '0;
      decim_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        trig_cap_pkg::CFG_TRIG_MODE:   trig_mode_q   <= cfg_wdata_i[2:0];
        trig_cap_pkg::CFG_TRIG_THRESH: trig_thresh_q <= cfg_wdata_i;
        trig_cap_pkg::CFG_DECIM:       decim_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input field unpack
  logic signed [SW-1:0] in_sample_a, in_sample_b, in_trig;
  logic                 in_clear, in_start;
  logic [trig_cap_pkg::IndexWidth-1:0] in_ridx;

  assign in_sample_a = s_axis_tdata[15:0];
  assign in_sample_b = s_axis_tdata[31:16];
  assign in_trig     = s_axis_tdata[47:32];
  assign in_clear    = s_axis_tdata[48];
  assign in_start    = s_axis_tdata[49];
  assign in_ridx     = s_axis_tdata[57:50];

  // recorder state
  logic [PosWidth-1:0] wpos_q, wpos_d;
  logic [PosWidth-1:0] hwm_q, hwm_d;      // entries below this hold written data
  logic [SW-1:0]       cnt_q, cnt_d;
  logic                armed_q, armed_d;
  logic                running_q, running_d;

  // control
  logic busy_q;                            // read in flight
  logic out_valid_q;
  logic accept, tick_acc, read_acc;

  assign s_axis_tready = !busy_q && (!out_valid_q || m_axis_tready);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign tick_acc = accept && (s_axis_tuser == trig_cap_pkg::OP_TICK);
  assign read_acc = accept && (s_axis_tuser == trig_cap_pkg::OP_READ);

  logic hit;
  always_comb begin
    case (trig_mode_q)
      trig_cap_pkg::TRIG_GT: hit = in_trig > trig_thresh_q;
      trig_cap_pkg::TRIG_LT: hit = in_trig < trig_thresh_q;
      trig_cap_pkg::TRIG_EQ: hit = in_trig == trig_thresh_q;
      trig_cap_pkg::TRIG_NE: hit = in_trig != trig_thresh_q;
      default:               hit = 1'b0;
    endcase
  end

  // tick update: clear, trigger, manual start, capture
  logic                 mem_we;
  logic [AddrWidth-1:0] mem_waddr;

  always_comb begin
    armed_d   = armed_q;
    running_d = running_q;
    wpos_d    = wpos_q;
    hwm_d     = hwm_q;
    cnt_d     = cnt_q;
    mem_we    = 1'b0;
    mem_waddr = wpos_q[AddrWidth-1:0];
    if (in_clear) begin
      armed_d = 1'b1;
      wpos_d  = '0;
      hwm_d   = '0;
    end
    if (armed_d && !running_d && hit) begin
      running_d = 1'b1;
      wpos_d    = '0;
    end
    if (in_start && !running_d) begin
      running_d = 1'b1;
      armed_d   = 1'b1;
    end
    mem_waddr = wpos_d[AddrWidth-1:0];
    if (running_d) begin
      if (32'(wpos_d) >= CaptureDepth) begin
        armed_d   = 1'b0;
        running_d = 1'b0;
      end else if (cnt_q == '0) begin
        mem_we = 1'b1;
        // writes are sequential from zero, so the written set stays a prefix
        if (wpos_d == hwm_d) hwm_d = hwm_d + 1'b1;
        wpos_d = wpos_d + 1'b1;
        cnt_d  = decim_q;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q    <= '0;
      hwm_q     <= '0;
      cnt_q     <= '0;
      armed_q   <= 1'b1;
      running_q <= 1'b0;
    end else if (tick_acc) begin
      wpos_q    <= wpos_d;
      hwm_q     <= hwm_d;
      cnt_q     <= cnt_d;
      armed_q   <= armed_d;
      running_q <= running_d;
    end
  end

  // capture memory: {sample_b, sample_a} per entry
  logic [2*SW-1:0] mem [CaptureDepth];
  logic [2*SW-1:0] rdata_q;
  logic            rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (tick_acc && mem_we) begin
      mem[mem_waddr] <= {in_sample_b, in_sample_a};
    end
    if (read_acc) begin
      rdata_q <= mem[AddrWidth'(in_ridx)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rd_hit_q <= 1'b0;
    end else begin
      busy_q <= read_acc;
      if (read_acc) begin
        rd_hit_q <= (32'(in_ridx) < CaptureDepth) && (32'(in_ridx) < 32'(hwm_q));
      end
    end
  end

  // output register
  logic [SW-1:0] out_live_a_q, out_live_b_q, out_rd_a_q, out_rd_b_q;
  logic          out_armed_q, out_running_q;
  logic [trig_cap_pkg::FillWidth-1:0] out_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_acc || busy_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      out_live_a_q  <= in_sample_a;
      out_live_b_q  <= in_sample_b;
      out_armed_q   <= armed_d;
      out_running_q <= running_d;
      out_fill_q    <= trig_cap_pkg::FillWidth'(wpos_d);
      out_rd_a_q    <= '0;
      out_rd_b_q    <= '0;
    end else if (busy_q) begin
      out_live_a_q  <= '0;
      out_live_b_q  <= '0;
      out_armed_q   <= armed_q;
      out_running_q <= running_q;
      out_fill_q    <= trig_cap_pkg::FillWidth'(wpos_q);
      out_rd_a_q    <= rd_hit_q ? rdata_q[SW-1:0]    : '0;
      out_rd_b_q    <= rd_hit_q ? rdata_q[2*SW-1:SW] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_rd_b_q, out_rd_a_q, out_fill_q, out_running_q,
                          out_armed_q, out_live_b_q, out_live_a_q};

endmodule
